### sv/tcw_pkg.sv
package tcw_pkg;

   localparam logic [1:0] KIND_PUT    = 2'd0;
   localparam logic [1:0] KIND_SETPOS = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam logic [7:0] CH_BS = 8'd8;
   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] CH_CR = 8'd13;

   localparam logic [1:0] CSR_FG   = 2'd0;
   localparam logic [1:0] CSR_BG   = 2'd1;
   localparam logic [1:0] CSR_CRLF = 2'd2;

   localparam logic [3:0] FG_RESET = 4'd7;
   localparam logic [3:0] BG_RESET = 4'd0;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 6;
   localparam int ADDR_W = 11;
   localparam int CELL_W = 16;
   localparam int POS_W  = 11;

   localparam int QDEPTH = 2;

   typedef enum logic [2:0] {
      OP_GLYPH,
      OP_LF,
      OP_CR,
      OP_BS,
      OP_SETPOS,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CELL_W-1:0]   glyph_attr;
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      logic [ADDR_W-1:0]   addr;
      logic                addr_ok;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qslot_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_RUN,
      BK_SCROLL,
      BK_READ
   } bk_state_type;

endpackage

### sv/tcw_if.sv
interface tcw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  char_code;
   logic [7:0]  col;
   logic [5:0]  row;
   logic [10:0] read_addr;
   modport source (output valid, kind, char_code, col, row, read_addr, input ready);
   modport sink (input valid, kind, char_code, col, row, read_addr, output ready);
endinterface

interface tcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] cursor_pos;
   logic        scrolled;
   logic [15:0] read_data;
   modport source (output valid, cursor_pos, scrolled, read_data, input ready);
   modport sink (input valid, cursor_pos, scrolled, read_data, output ready);
endinterface

interface tcw_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [3:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### sv/tcw_front.sv
module tcw_front #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   tcw_req_if.sink             req_bus,
   input  logic [3:0]          fg_colour,
   input  logic [3:0]          bg_colour,
   input  logic                q_full,
   output tcw_pkg::qslot_type  q_push
);

   localparam int CELLS = COLS * ROWS;

   tcw_pkg::item_type item;

   always_comb begin
      item.op = tcw_pkg::OP_NOP;
      case (req_bus.kind)
         tcw_pkg::KIND_PUT: begin
            case (req_bus.char_code)
               tcw_pkg::CH_LF: item.op = tcw_pkg::OP_LF;
               tcw_pkg::CH_CR: item.op = tcw_pkg::OP_CR;
               tcw_pkg::CH_BS: item.op = tcw_pkg::OP_BS;
               default:        item.op = tcw_pkg::OP_GLYPH;
            endcase
         end
         tcw_pkg::KIND_SETPOS: item.op = tcw_pkg::OP_SETPOS;
         tcw_pkg::KIND_READ:   item.op = tcw_pkg::OP_READ;
         default:              item.op = tcw_pkg::OP_NOP;
      endcase
      item.glyph_attr = {bg_colour, fg_colour, req_bus.char_code};
      item.col  = (req_bus.col > 8'(COLS - 1)) ? tcw_pkg::COL_W'(COLS - 1)
                                               : req_bus.col[tcw_pkg::COL_W-1:0];
      item.row  = (req_bus.row > 6'(ROWS - 1)) ? tcw_pkg::ROW_W'(ROWS - 1) : req_bus.row;
      item.addr = req_bus.read_addr;
      item.addr_ok = (32'(req_bus.read_addr) < CELLS);
   end

   assign req_bus.ready = !q_full;
   assign q_push.valid  = req_bus.valid && !q_full;
   assign q_push.item   = item;

endmodule

### sv/tcw_queue.sv
module tcw_queue (
   input  logic                clock,
   input  logic                reset,
   input  tcw_pkg::qslot_type  q_push,
   input  logic                q_pop,
   output logic                q_full,
   output tcw_pkg::qslot_type  q_head
);

   localparam int PW = (tcw_pkg::QDEPTH > 1) ? $clog2(tcw_pkg::QDEPTH) : 1;
   localparam int CNT_W = $clog2(tcw_pkg::QDEPTH + 1);

   tcw_pkg::item_type slot_ff [tcw_pkg::QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign q_full  = (count_ff == CNT_W'(tcw_pkg::QDEPTH));
   assign do_push = q_push.valid && !q_full;
   assign do_pop  = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(tcw_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(tcw_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_push.item;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = slot_ff[rd_ptr_ff];

endmodule

### sv/tcw_back.sv
module tcw_back #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                crlf_mode,
   input  tcw_pkg::qslot_type  q_head,
   output logic                q_pop,
   tcw_rsp_if.source           rsp_bus
);

   localparam int CELLS = COLS * ROWS;
   localparam int AW = $clog2(CELLS);
   localparam int CW = $clog2(COLS);
   localparam int RW = $clog2(ROWS);
   localparam logic [CW-1:0] LAST_COL   = CW'(COLS - 1);
   localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
   localparam logic [AW-1:0] COLS_A     = AW'(COLS);
   localparam logic [AW-1:0] CELLS_LAST = AW'(CELLS - 1);
   localparam logic [AW-1:0] TOP_LAST   = AW'(CELLS - COLS);

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] a, input logic [AW-1:0] o);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, o};
      if (s >= (AW + 1)'(CELLS)) begin
         s = s - (AW + 1)'(CELLS);
      end
      return s[AW-1:0];
   endfunction

   tcw_pkg::bk_state_type state_ff, state_in;

   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [AW-1:0]   pos_ff, pos_in;
   logic [AW-1:0]   off_ff, off_in;
   logic [AW-1:0]   cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [10:0]     rsp_pos_ff, rsp_pos_in;
   logic            rsp_scr_ff, rsp_scr_in;
   logic [15:0]     rsp_data_ff, rsp_data_in;
   logic [15:0]     rd_data_ff;
   logic [15:0]     mem [CELLS];

   logic            mem_we, mem_re;
   logic [AW-1:0]   mem_wa, mem_ra;
   logic [15:0]     mem_wd;
   logic            out_free, scroll_hit, read_go;
   logic [AW-1:0]   lf_base;
   tcw_pkg::item_type it;

   assign it       = q_head.item;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign q_pop    = (state_ff == tcw_pkg::BK_RUN) && q_head.valid && out_free;
   assign scroll_hit = (row_ff == LAST_ROW) && ((it.op == tcw_pkg::OP_LF) ||
                       ((it.op == tcw_pkg::OP_GLYPH) && (col_ff == LAST_COL)));
   assign read_go  = (it.op == tcw_pkg::OP_READ) && it.addr_ok;
   assign lf_base  = crlf_mode ? pos_ff : pos_ff - AW'(col_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::BK_CLEAR: begin
            if (cnt_ff == CELLS_LAST) state_in = tcw_pkg::BK_RUN;
         end
         tcw_pkg::BK_RUN: begin
            if (q_pop) begin
               if (scroll_hit) state_in = tcw_pkg::BK_SCROLL;
               else if (read_go) state_in = tcw_pkg::BK_READ;
            end
         end
         tcw_pkg::BK_SCROLL: begin
            if (cnt_ff == AW'(COLS - 1)) state_in = tcw_pkg::BK_RUN;
         end
         tcw_pkg::BK_READ: state_in = tcw_pkg::BK_RUN;
         default: state_in = tcw_pkg::BK_CLEAR;
      endcase
   end

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      pos_in       = pos_ff;
      off_in       = off_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_scr_in   = rsp_scr_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = phys(pos_ff, off_ff);
      mem_wd       = it.glyph_attr;
      mem_re       = 1'b0;
      mem_ra       = phys(AW'(it.addr), off_ff);
      case (state_ff)
         tcw_pkg::BK_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            mem_wd = '0;
            cnt_in = (cnt_ff == CELLS_LAST) ? '0 : cnt_ff + 1'b1;
         end
         tcw_pkg::BK_RUN: begin
            if (q_pop) begin
               case (it.op)
                  tcw_pkg::OP_GLYPH: begin
                     mem_we = 1'b1;
                     if (col_ff == LAST_COL) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           pos_in = pos_ff - AW'(COLS - 1);
                        end else begin
                           row_in = row_ff + 1'b1;
                           pos_in = pos_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                        pos_in = pos_ff + 1'b1;
                     end
                  end
                  tcw_pkg::OP_LF: begin
                     if (!crlf_mode) col_in = '0;
                     if (row_ff == LAST_ROW) begin
                        pos_in = lf_base;
                     end else begin
                        row_in = row_ff + 1'b1;
                        pos_in = lf_base + COLS_A;
                     end
                  end
                  tcw_pkg::OP_CR: begin
                     if (crlf_mode) begin
                        col_in = '0;
                        pos_in = pos_ff - AW'(col_ff);
                     end
                  end
                  tcw_pkg::OP_BS: begin
                     if (pos_ff != '0) begin
                        pos_in = pos_ff - 1'b1;
                        if (col_ff == '0) begin
                           col_in = LAST_COL;
                           row_in = row_ff - 1'b1;
                        end else begin
                           col_in = col_ff - 1'b1;
                        end
                     end
                  end
                  tcw_pkg::OP_SETPOS: begin
                     col_in = CW'(it.col);
                     row_in = RW'(it.row);
                     pos_in = AW'(32'(it.row) * COLS + 32'(it.col));
                  end
                  tcw_pkg::OP_READ: begin
                     mem_re = read_go;
                  end
                  default: begin
                  end
               endcase
               cnt_in       = '0;
               rsp_pos_in   = 11'(pos_in);
               rsp_scr_in   = scroll_hit;
               rsp_data_in  = '0;
               rsp_valid_in = !(scroll_hit || read_go);
            end
         end
         tcw_pkg::BK_SCROLL: begin
            mem_we = 1'b1;
            mem_wa = off_ff + cnt_ff;
            mem_wd = '0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == AW'(COLS - 1)) begin
               cnt_in       = '0;
               off_in       = (off_ff == TOP_LAST) ? '0 : off_ff + COLS_A;
               rsp_valid_in = 1'b1;
            end
         end
         tcw_pkg::BK_READ: begin
            rsp_data_in  = rd_data_ff;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::BK_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         pos_ff       <= '0;
         off_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pos_ff       <= pos_in;
         off_ff       <= off_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff  <= rsp_pos_in;
      rsp_scr_ff  <= rsp_scr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.cursor_pos = rsp_pos_ff;
   assign rsp_bus.scrolled   = rsp_scr_ff;
   assign rsp_bus.read_data  = rsp_data_ff;

endmodule

### sv/text_console_writer.sv
// Text console engine over a ROWS x COLS screen of 16-bit cells
// (glyph in bits 7:0, foreground 11:8, background 15:12).
// req_bus: put character (newline, return, backspace or glyph), set cursor,
// or read one cell. Items land in a two-entry queue and are executed in order.
// rsp_bus: one result per item with the cursor position after it, the scroll
// flag, and the cell value for reads (zero otherwise).
// csr_bus: index 0 foreground, 1 background, 2 CRLF mode; always ready.
// Write it only while no item is in flight.
// An in-range read goes through a registered read of the screen store, and
// an item that scrolls clears one row of the store one cell per cycle
// (scroll moves a row base offset, no cell copies); the next item waits
// until either is done. Responses are registered.
// Reset: cursor to home, colours to light gray on black, then a clearing
// sweep of all ROWS * COLS cells; requests queue up but execute after it.
// A stalled response holds its register; the queue then fills and req ready
// drops.
module text_console_writer #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input logic        clock,
   input logic        reset,
   tcw_req_if.sink    req_bus,
   tcw_rsp_if.source  rsp_bus,
   tcw_csr_if.sink    csr_bus
);

   logic [3:0] fg_ff, fg_in;
   logic [3:0] bg_ff, bg_in;
   logic       crlf_ff, crlf_in;

   tcw_pkg::qslot_type q_push, q_head;
   logic               q_full, q_pop;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      fg_in   = fg_ff;
      bg_in   = bg_ff;
      crlf_in = crlf_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            tcw_pkg::CSR_FG:   fg_in   = csr_bus.data;
            tcw_pkg::CSR_BG:   bg_in   = csr_bus.data;
            tcw_pkg::CSR_CRLF: crlf_in = csr_bus.data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff   <= tcw_pkg::FG_RESET;
         bg_ff   <= tcw_pkg::BG_RESET;
         crlf_ff <= 1'b0;
      end else begin
         fg_ff   <= fg_in;
         bg_ff   <= bg_in;
         crlf_ff <= crlf_in;
      end
   end

   tcw_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
      .req_bus   (req_bus),
      .fg_colour (fg_ff),
      .bg_colour (bg_ff),
      .q_full    (q_full),
      .q_push    (q_push)
   );

   tcw_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_full (q_full),
      .q_head (q_head)
   );

   tcw_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .crlf_mode (crlf_ff),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_bus   (rsp_bus)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("pop from empty queue");

   a_scroll_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.scrolled |->
         (32'(rsp_bus.cursor_pos) >= (ROWS - 1) * COLS) || (ROWS * COLS > 2048))
      else $error("scroll reported with cursor off the last row");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (32'(rsp_bus.cursor_pos) < ROWS * COLS) || (ROWS * COLS > 2048))
      else $error("cursor position beyond screen");

   a_push_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !q_head.valid)
      else $error("queue not empty after reset");

endmodule
